// ----- rtl/assert_macros.svh -----
// Assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/lcs_pkg.sv -----
package lcs_pkg;

	localparam int CP_W = 21;
	localparam int RATIO_W = 23;
	localparam int COMMON_W = 11;
	localparam int TOTAL_W = 12;
	localparam int FRAC_W = 16;
	localparam logic [RATIO_W-1:0] RATIO_FULL = RATIO_W'(100 << FRAC_W);

	typedef struct packed {
		logic [CP_W-1:0] codepoint;
		logic side;
		logic has_char;
		logic end_of_pair;
	} in_item_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio_fixed;
		logic [COMMON_W-1:0] common_length;
		logic [TOTAL_W-1:0] total_length;
		logic too_long;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic row_start;
		logic col_step;
		logic div_start;
		logic clear;
	} lcs_cmd_t;

	typedef struct packed {
		logic col_last;
		logic row_last;
		logic div_done;
		logic empty_any;
	} lcs_stat_t;

endpackage

// ----- rtl/lcs_if.sv -----
interface lcs_in_if import lcs_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcs_out_if import lcs_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lcs_ctrl.sv -----
`include "assert_macros.svh"
module lcs_ctrl import lcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic in_end,
	input lcs_stat_t stat,
	input logic out_busy,
	input logic out_ready,
	output lcs_cmd_t cmd,
	output logic in_ready,
	output logic out_load
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_ROW = 3'd1;
	localparam logic [2:0] ST_COL = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
				if (in_fire && in_end) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.empty_any) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.row_start = 1'b1;
					state_d = ST_COL;
				end
			end
			ST_ROW: begin
				cmd.row_start = 1'b1;
				state_d = ST_COL;
			end
			ST_COL: begin
				cmd.col_step = 1'b1;
				if (stat.col_last) begin
					if (stat.row_last) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_ROW;
					end
				end
			end
			ST_DIV: begin
				if (stat.div_done && !out_busy) begin
					out_load = 1'b1;
					cmd.clear = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	logic div_kick_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			div_kick_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_kick_q <= (state_q == ST_COL) && stat.col_last && stat.row_last;
		end
	end

	`ASSERT_NEVER(a_no_load_busy, (state_q != ST_LOAD) && cmd.load, "load outside load state")
	`ASSERT_CLK(a_out_once, out_load |=> !out_load, "double result load")
	`ASSERT_NEVER(a_kick_state, div_kick_q && (state_q != ST_DIV), "divider kick lost")
	`ASSERT_NEVER(a_out_ready_x, out_load && out_busy && !out_ready, "result overwritten")

endmodule

// ----- rtl/lcs_dp.sv -----
`include "assert_macros.svh"
module lcs_dp import lcs_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input logic clk,
	input logic arst_n,
	input in_item_t in_data,
	input lcs_cmd_t cmd,
	input logic div_kick,
	output lcs_stat_t stat,
	output out_item_t result
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int TW = CW + 1;
	// The scale 200 * 2^16 fits in 24 bits, so the numerator needs CW + 24 bits.
	localparam int NUM_W = CW + 24;

	logic [CP_W-1:0] left_mem [MAX_LEN];
	logic [CP_W-1:0] right_mem [MAX_LEN];
	logic [CW-1:0] row_mem [MAX_LEN];

	logic [CW-1:0] left_cnt_q, right_cnt_q;
	logic ovf_q;

	// Row index j over right string, column index i over left string.
	logic [CW-1:0] j_q, i_q;
	logic [CP_W-1:0] rc_q;
	logic [CW-1:0] diag_q, leftval_q;
	logic [CP_W-1:0] lrd;
	logic [CW-1:0] uprd;
	logic [CW-1:0] v;
	logic pend_q;
	logic first_q;

	wire [AW-1:0] i_a = AW'(i_q);

	always_ff @(posedge clk) begin
		if (cmd.load && in_data.has_char) begin
			if (in_data.side && (right_cnt_q < CW'(MAX_LEN)))
				right_mem[AW'(right_cnt_q)] <= in_data.codepoint;
			if (!in_data.side && (left_cnt_q < CW'(MAX_LEN)))
				left_mem[AW'(left_cnt_q)] <= in_data.codepoint;
		end
	end

	// Reads for column i are issued in the cycle before column i is computed.
	logic [CW-1:0] rd_i;
	assign rd_i = cmd.row_start ? '0 : i_q + CW'(1);
	always_ff @(posedge clk) begin
		lrd <= left_mem[AW'(rd_i)];
		uprd <= row_mem[AW'(rd_i)];
		if (cmd.row_start) rc_q <= right_mem[AW'(j_q)];
	end

	// First row treats stored entries as zero.
	wire [CW-1:0] up = first_q ? '0 : uprd;
	assign v = (lrd == rc_q) ? diag_q + CW'(1) : ((leftval_q > up) ? leftval_q : up);

	always_ff @(posedge clk) begin
		if (cmd.col_step) row_mem[i_a] <= v;
	end

	assign stat.col_last = (i_q == left_cnt_q - CW'(1));
	assign stat.row_last = (j_q == right_cnt_q - CW'(1));
	assign stat.empty_any = ovf_q || (left_cnt_q == '0) || (right_cnt_q == '0);

	logic [CW-1:0] lcs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cnt_q <= '0;
			right_cnt_q <= '0;
			ovf_q <= 1'b0;
			j_q <= '0;
			i_q <= '0;
			first_q <= 1'b1;
			pend_q <= 1'b0;
		end else begin
			if (cmd.load && in_data.has_char) begin
				if (in_data.side) begin
					if (right_cnt_q < CW'(MAX_LEN)) right_cnt_q <= right_cnt_q + CW'(1);
					else ovf_q <= 1'b1;
				end else begin
					if (left_cnt_q < CW'(MAX_LEN)) left_cnt_q <= left_cnt_q + CW'(1);
					else ovf_q <= 1'b1;
				end
			end
			if (cmd.row_start) begin
				i_q <= '0;
				pend_q <= 1'b1;
			end
			if (cmd.col_step) begin
				i_q <= i_q + CW'(1);
				if (stat.col_last) begin
					j_q <= j_q + CW'(1);
					first_q <= 1'b0;
				end
			end
			if (cmd.clear) begin
				left_cnt_q <= '0;
				right_cnt_q <= '0;
				ovf_q <= 1'b0;
				j_q <= '0;
				first_q <= 1'b1;
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_start) begin
			diag_q <= '0;
			leftval_q <= '0;
		end else if (cmd.col_step) begin
			diag_q <= up;
			leftval_q <= v;
			if (stat.col_last) lcs_q <= v;
		end
	end

	// Restoring divider: floor(200*65536*lcs / total), one quotient bit per cycle.
	logic [TW-1:0] total;
	assign total = TW'(left_cnt_q) + TW'(right_cnt_q);
	logic [NUM_W+TW-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [NUM_W+TW-1:0] trial;
	assign trial = {rem_q[NUM_W+TW-2:0], num_q[NUM_W-1]};
	logic [CW-1:0] lcs_use;
	assign lcs_use = stat.empty_any ? '0 : lcs_q;
	logic [NUM_W+CW-1:0] prod;
	assign prod = (NUM_W+CW)'(lcs_use) * (NUM_W+CW)'(200 << FRAC_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd.div_start || div_kick) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q <= 6'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (cmd.clear) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start || div_kick) begin
			rem_q <= '0;
			num_q <= NUM_W'(prod);
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= (NUM_W+TW)'(total)) begin
				rem_q <= trial - (NUM_W+TW)'(total);
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end
	assign stat.div_done = done_q;

	always_comb begin
		result = '0;
		if (ovf_q) begin
			result.too_long = 1'b1;
		end else if (total == '0) begin
			result.ratio_fixed = RATIO_FULL;
		end else if (!stat.empty_any) begin
			result.ratio_fixed = RATIO_W'(quo_q);
			result.common_length = COMMON_W'(lcs_q);
			result.total_length = TOTAL_W'(total);
		end else begin
			result.total_length = TOTAL_W'(total);
		end
	end

	`ASSERT_NEVER(a_left_cnt, left_cnt_q > CW'(MAX_LEN), "left count overflow")
	`ASSERT_NEVER(a_step_load, cmd.col_step && cmd.load, "compute during load")
	`ASSERT_CLK(a_pend, cmd.row_start |=> pend_q, "row start lost")

endmodule

// ----- rtl/lcs_indel_similarity_ratio.sv -----
// Loads two strings one codepoint per cycle; on the end-of-pair item the LCS is computed
// with one DP cell per cycle within a row over a rolling row held in block memory, then a
// restoring divider forms the ratio one quotient bit per cycle. A pair with an empty string
// or an overflow skips the LCS and goes straight to the divider. The result load waits while
// the previous result is still held by the output, and input is accepted again only after
// the ST_OUT state that follows the result load; no new pair is taken while one is in work.
module lcs_indel_similarity_ratio import lcs_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input logic clk,
	input logic arst_n,
	lcs_in_if.sink in_ch,
	lcs_out_if.source out_ch
);

	lcs_cmd_t cmd;
	lcs_stat_t stat;
	out_item_t result;
	logic out_load;
	logic in_ready;
	logic out_valid_q;
	out_item_t out_q;
	logic kick_q;

	assign in_ch.ready = in_ready;
	wire in_fire = in_ch.valid && in_ready;

	lcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_end(in_ch.data.end_of_pair),
		.stat(stat), .out_busy(out_valid_q && !out_ch.ready), .out_ready(out_ch.ready),
		.cmd(cmd), .in_ready(in_ready), .out_load(out_load)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kick_q <= 1'b0;
		else kick_q <= cmd.col_step && stat.col_last && stat.row_last;
	end

	lcs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_ch.data), .cmd(cmd),
		.div_kick(kick_q), .stat(stat), .result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) out_q <= result;
	end
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

endmodule
